// ===== rtl/psd_pkg.sv =====
// Shared types, widths and codes for the polygon signed distance block.
package psd_pkg;

    localparam int COORD_BITS = 32;
    localparam int PROJ_BITS  = 32;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int MUL_W      = COORD_BITS + 4;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ROOT_W     = MUL_W;
    localparam int H_W        = PROJ_BITS + 1;
    localparam int DIST_W     = COORD_BITS - 1;
    localparam int CNT_W      = 6;
    localparam int DIV_ITERS  = PROJ_BITS;
    localparam int SQ_ITERS   = ROOT_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Multiplier operation codes, issued in order by the controller.
    localparam logic [3:0] MS_T0  = 4'd0;
    localparam logic [3:0] MS_T1  = 4'd1;
    localparam logic [3:0] MS_L0  = 4'd2;
    localparam logic [3:0] MS_L1  = 4'd3;
    localparam logic [3:0] MS_C1  = 4'd4;
    localparam logic [3:0] MS_C2  = 4'd5;
    localparam logic [3:0] MS_PX  = 4'd6;
    localparam logic [3:0] MS_PY  = 4'd7;
    localparam logic [3:0] MS_N0  = 4'd8;
    localparam logic [3:0] MS_N1  = 4'd9;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] query_x;
        logic signed [COORD_BITS-1:0] query_y;
        logic signed [COORD_BITS-1:0] vertex_x;
        logic signed [COORD_BITS-1:0] vertex_y;
        logic                         first_vertex;
        logic                         last_vertex;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] signed_distance;
        logic                         is_inside;
        logic                         too_few_vertices;
    } t_out;

    typedef struct packed {
        logic       accept;
        logic       init;
        logic       load;
        logic       edge_sel;
        logic       mul_en;
        logic [3:0] mul_sel;
        logic       div_init;
        logic       div_step;
        logic       sq_init;
        logic       sq_step;
        logic       edge_end;
        logic       emit;
        logic       few;
    } t_cmd;

    typedef struct packed {
        logic div_needed;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/psd_ctrl.sv =====
// Controller state machine that sequences vertices, edges and results.
module psd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  psd_pkg::t_in     i_in_data,
    output logic             o_in_stall,
    input  psd_pkg::t_status i_status,
    output psd_pkg::t_cmd    o_cmd
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_LOAD     = 4'd1;
    localparam logic [3:0] S_MUL_A    = 4'd2;
    localparam logic [3:0] S_DIV_INIT = 4'd3;
    localparam logic [3:0] S_DIV      = 4'd4;
    localparam logic [3:0] S_MUL_B    = 4'd5;
    localparam logic [3:0] S_SQ_INIT  = 4'd6;
    localparam logic [3:0] S_SQ       = 4'd7;
    localparam logic [3:0] S_EDGE_END = 4'd8;
    localparam logic [3:0] S_EMIT     = 4'd9;

    logic [3:0]                 r_state, n_state;
    logic [psd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic [1:0]                 r_seen, n_seen;
    logic                       r_phase, n_phase;
    logic                       r_last, n_last;
    logic                       r_few, n_few;

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_seen  = r_seen;
        n_phase = r_phase;
        n_last  = r_last;
        n_few   = r_few;
        o_cmd   = '0;
        o_cmd.edge_sel = r_phase;
        o_cmd.few      = r_few;
        o_cmd.mul_sel  = r_cnt[3:0];
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_last = i_in_data.last_vertex;
                    if (i_in_data.first_vertex || r_seen == 2'd0) begin
                        o_cmd.init = 1'b1;
                        n_seen = 2'd1;
                        if (i_in_data.last_vertex) begin
                            n_few   = 1'b1;
                            n_state = S_EMIT;
                        end
                    end else begin
                        if (r_seen != 2'd3) begin
                            n_seen = r_seen + 2'd1;
                        end
                        n_phase = 1'b0;
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = '0;
                n_state = S_MUL_A;
            end
            S_MUL_A: begin
                o_cmd.mul_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == psd_pkg::MS_C2) begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt = '0;
                if (i_status.div_needed) begin
                    n_state = S_DIV;
                end else begin
                    n_cnt   = psd_pkg::CNT_W'(psd_pkg::MS_PX);
                    n_state = S_MUL_B;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == psd_pkg::CNT_W'(psd_pkg::DIV_ITERS - 1)) begin
                    n_cnt   = psd_pkg::CNT_W'(psd_pkg::MS_PX);
                    n_state = S_MUL_B;
                end
            end
            S_MUL_B: begin
                o_cmd.mul_en = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[3:0] == psd_pkg::MS_N1) begin
                    n_state = S_SQ_INIT;
                end
            end
            S_SQ_INIT: begin
                o_cmd.sq_init = 1'b1;
                n_cnt   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == psd_pkg::CNT_W'(psd_pkg::SQ_ITERS - 1)) begin
                    n_state = S_EDGE_END;
                end
            end
            S_EDGE_END: begin
                o_cmd.edge_end = 1'b1;
                if (r_phase) begin
                    n_few   = 1'b0;
                    n_state = S_EMIT;
                end else if (r_last) begin
                    if (r_seen == 2'd3) begin
                        n_phase = 1'b1;
                        n_state = S_LOAD;
                    end else begin
                        n_few   = 1'b1;
                        n_state = S_EMIT;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_seen  = 2'd0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_seen  <= 2'd0;
            r_phase <= 1'b0;
            r_last  <= 1'b0;
            r_few   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_seen  <= n_seen;
            r_phase <= n_phase;
            r_last  <= n_last;
            r_few   <= n_few;
        end
    end

endmodule

// ===== rtl/psd_dp.sv =====
// Datapath: edge arithmetic, shared multiplier, divider, square root and result register.
module psd_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  psd_pkg::t_in     i_in_data,
    input  psd_pkg::t_cmd    i_cmd,
    output psd_pkg::t_status o_status,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output psd_pkg::t_out    o_out_data
);

    localparam int CW = psd_pkg::COORD_BITS;
    localparam int DW = psd_pkg::DIFF_W;
    localparam int MW = psd_pkg::MUL_W;
    localparam int PW = psd_pkg::PROD_W;
    localparam int RW = psd_pkg::ROOT_W;
    localparam int HW = psd_pkg::H_W;

    logic signed [CW-1:0] r_qx, r_qy, r_vx, r_vy, r_sx, r_sy, r_px, r_py;
    logic signed [DW-1:0] r_abx, r_aby, r_aqx, r_aqy;
    logic                 r_ycross;
    logic signed [PW-1:0] r_t, r_len, r_c1, r_c2, r_prod;
    logic [PW-1:0]        r_n, r_rem;
    logic                 r_wb_en;
    logic [3:0]           r_wb_sel;
    logic [HW-1:0]        r_h;
    logic signed [MW-1:0] r_ex, r_ey;
    logic [RW-1:0]        r_root;
    logic [RW+1:0]        r_srem;
    logic [psd_pkg::DIST_W-1:0] r_least;
    logic                 r_parity;
    logic                 r_out_valid;
    psd_pkg::t_out        r_out;

    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [MW-1:0] w_opa, w_opb, w_pr;
    logic signed [PW-1:0] w_mul, w_pmag, w_rsum;
    logic [MW-1:0]        w_m;
    logic                 w_t_pos, w_len_zero, w_t_ge;
    logic [PW-1:0]        w_r2;
    logic [RW+3:0]        w_cur, w_trial;
    logic [psd_pkg::DIST_W-1:0] w_d;
    logic                 w_dy_pos, w_cross;
    logic signed [CW-1:0] w_dist;

    // Edge end points: previous to current, or the closing edge current to start.
    assign w_ax = i_cmd.edge_sel ? r_vx : r_px;
    assign w_ay = i_cmd.edge_sel ? r_vy : r_py;
    assign w_bx = i_cmd.edge_sel ? r_sx : r_vx;
    assign w_by = i_cmd.edge_sel ? r_sy : r_vy;

    // Operand selection for the shared multiplier.
    always_comb begin
        case (i_cmd.mul_sel)
            psd_pkg::MS_T0: begin w_opa = MW'(r_aqx); w_opb = MW'(r_abx); end
            psd_pkg::MS_T1: begin w_opa = MW'(r_aqy); w_opb = MW'(r_aby); end
            psd_pkg::MS_L0: begin w_opa = MW'(r_abx); w_opb = MW'(r_abx); end
            psd_pkg::MS_L1: begin w_opa = MW'(r_aby); w_opb = MW'(r_aby); end
            psd_pkg::MS_C1: begin w_opa = MW'(r_aqx); w_opb = MW'(r_aby); end
            psd_pkg::MS_C2: begin w_opa = MW'(r_abx); w_opb = MW'(r_aqy); end
            psd_pkg::MS_PX: begin w_opa = MW'(r_abx); w_opb = $signed(MW'(r_h)); end
            psd_pkg::MS_PY: begin w_opa = MW'(r_aby); w_opb = $signed(MW'(r_h)); end
            psd_pkg::MS_N0: begin w_opa = r_ex; w_opb = r_ex; end
            psd_pkg::MS_N1: begin w_opa = r_ey; w_opb = r_ey; end
            default:        begin w_opa = '0; w_opb = '0; end
        endcase
    end

    assign w_mul = w_opa * w_opb;

    // Projection rounding: magnitude rounded half away from zero, sign restored.
    assign w_pmag = r_prod[PW-1] ? -r_prod : r_prod;
    assign w_rsum = w_pmag + (PW'(1) << (psd_pkg::PROJ_BITS - 1));
    assign w_m    = w_rsum[psd_pkg::PROJ_BITS +: MW];
    assign w_pr   = r_prod[PW-1] ? -$signed(w_m) : $signed(w_m);

    // Division decision on the projection parameter.
    assign w_len_zero = (r_len == '0);
    assign w_t_pos    = !r_t[PW-1] && (r_t != '0);
    assign w_t_ge     = (r_t >= r_len);
    assign o_status.div_needed = !w_len_zero && w_t_pos && !w_t_ge;
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    // One restoring division step and one square root digit.
    assign w_r2    = r_rem << 1;
    assign w_cur   = {r_srem, r_n[PW-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};

    // Edge close: saturated distance and ray crossing.
    assign w_d      = (r_root > RW'(psd_pkg::DIST_MAX)) ? psd_pkg::DIST_MAX
                                                        : r_root[psd_pkg::DIST_W-1:0];
    assign w_dy_pos = !r_aby[DW-1] && (r_aby != '0);
    assign w_cross  = r_ycross && (w_dy_pos ? (r_c1 < r_c2) : (r_c1 > r_c2));
    assign w_dist   = r_parity ? -$signed({1'b0, r_least}) : $signed({1'b0, r_least});

    // Input capture and stored vertices.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx <= '0;
            r_sy <= '0;
            r_px <= '0;
            r_py <= '0;
        end else begin
            if (i_cmd.init) begin
                r_sx <= i_in_data.vertex_x;
                r_sy <= i_in_data.vertex_y;
                r_px <= i_in_data.vertex_x;
                r_py <= i_in_data.vertex_y;
            end else if (i_cmd.load && !i_cmd.edge_sel) begin
                r_px <= r_vx;
                r_py <= r_vy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_qx <= i_in_data.query_x;
            r_qy <= i_in_data.query_y;
            r_vx <= i_in_data.vertex_x;
            r_vy <= i_in_data.vertex_y;
        end
        if (i_cmd.load) begin
            r_abx    <= DW'(w_bx) - DW'(w_ax);
            r_aby    <= DW'(w_by) - DW'(w_ay);
            r_aqx    <= DW'(r_qx) - DW'(w_ax);
            r_aqy    <= DW'(r_qy) - DW'(w_ay);
            r_ycross <= (w_ay > r_qy) != (w_by > r_qy);
        end
    end

    // Multiplier with registered product, written back in the following cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_en <= 1'b0;
        end else begin
            r_wb_en <= i_cmd.mul_en;
        end
        r_prod   <= w_mul;
        r_wb_sel <= i_cmd.mul_sel;
        if (r_wb_en) begin
            case (r_wb_sel)
                psd_pkg::MS_T0: r_t   <= r_prod;
                psd_pkg::MS_T1: r_t   <= r_t + r_prod;
                psd_pkg::MS_L0: r_len <= r_prod;
                psd_pkg::MS_L1: r_len <= r_len + r_prod;
                psd_pkg::MS_C1: r_c1  <= r_prod;
                psd_pkg::MS_C2: r_c2  <= r_prod;
                psd_pkg::MS_PX: r_ex  <= MW'(r_aqx) - w_pr;
                psd_pkg::MS_PY: r_ey  <= MW'(r_aqy) - w_pr;
                psd_pkg::MS_N0: r_n   <= $unsigned(r_prod);
                psd_pkg::MS_N1: r_n   <= r_n + $unsigned(r_prod);
                default: ;
            endcase
        end else if (i_cmd.sq_step) begin
            r_n <= r_n << 2;
        end
    end

    // Projection parameter: clamped ends or a bit-serial quotient.
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_rem <= $unsigned(r_t);
            if (w_len_zero || !w_t_pos) begin
                r_h <= '0;
            end else if (w_t_ge) begin
                r_h <= HW'(1) << psd_pkg::PROJ_BITS;
            end else begin
                r_h <= '0;
            end
        end else if (i_cmd.div_step) begin
            if (w_r2 >= $unsigned(r_len)) begin
                r_rem <= w_r2 - $unsigned(r_len);
                r_h   <= {r_h[HW-2:0], 1'b1};
            end else begin
                r_rem <= w_r2;
                r_h   <= {r_h[HW-2:0], 1'b0};
            end
        end
    end

    // Integer square root, two radicand bits a cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_init) begin
            r_root <= '0;
            r_srem <= '0;
        end else if (i_cmd.sq_step) begin
            if (w_cur >= w_trial) begin
                r_srem <= (RW+2)'(w_cur - w_trial);
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_srem <= w_cur[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    // Running least distance and parity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_least  <= psd_pkg::DIST_MAX;
            r_parity <= 1'b0;
        end else if (i_cmd.init || i_cmd.emit) begin
            r_least  <= psd_pkg::DIST_MAX;
            r_parity <= 1'b0;
        end else if (i_cmd.edge_end) begin
            if (w_d < r_least) begin
                r_least <= w_d;
            end
            r_parity <= r_parity ^ w_cross;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            if (i_cmd.few) begin
                r_out.signed_distance  <= $signed({1'b0, psd_pkg::DIST_MAX});
                r_out.is_inside        <= 1'b0;
                r_out.too_few_vertices <= 1'b1;
            end else begin
                r_out.signed_distance  <= w_dist;
                r_out.is_inside        <= r_parity;
                r_out.too_few_vertices <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/polygon_signed_distance.sv =====
// Top level: signed distance from a query point to a streamed polygon.
// A vertex that opens a polygon is only stored; every other vertex processes its edge,
// with the 32-step divide only when the projection needs it.
// A last vertex adds the closing edge (with three or more vertices) and loads the result register.
// The shared multiplier, the bit-serial divider and the square root set the rate.
// Reset is synchronous and active low; it empties the result register and the polygon state.
module polygon_signed_distance (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  psd_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output psd_pkg::t_out o_out_data
);

    psd_pkg::t_cmd    w_cmd;
    psd_pkg::t_status w_status;

    // Sequencer.
    psd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and result register.
    psd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/psd_checker.sv =====
// Port-level checker for the polygon signed distance block, with its bind.
module psd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input psd_pkg::t_out o_out_data
);

    // A stalled result transaction keeps its payload.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // Reset empties the result register.
    assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A short polygon reports the maximum distance and outside.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.too_few_vertices |->
            !o_out_data.is_inside && !o_out_data.signed_distance[psd_pkg::COORD_BITS-1]
            && (o_out_data.signed_distance[psd_pkg::COORD_BITS-2:0] == psd_pkg::DIST_MAX))
        else $error("short polygon result malformed");

    // The sign of the distance follows the inside flag.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_out_data.is_inside || !o_out_data.signed_distance[psd_pkg::COORD_BITS-1])
            && (!o_out_data.is_inside || o_out_data.signed_distance[psd_pkg::COORD_BITS-1]
                || (o_out_data.signed_distance == '0)))
        else $error("distance sign disagrees with inside flag");

endmodule

bind polygon_signed_distance psd_checker u_psd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== sim/polygon_signed_distance_checker.sv =====
// Checker for the polygon signed distance block: predicts each result and compares it.
`timescale 1ns / 100ps

module polygon_signed_distance_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_stall,
    input  psd_pkg::t_in  i_in_data,
    input  logic          i_out_valid,
    input  logic          i_out_stall,
    input  psd_pkg::t_out i_out_data,
    output int            o_fail_count,
    output int            o_pending
);

    localparam logic [63:0] SAT_MAX = 64'h7FFF_FFFF;

    // Running polygon state, mirrored from the block's behaviour.
    longint      first_x, first_y, last_x, last_y;
    logic [63:0] nearest;
    logic        odd_crossings;
    int          vertex_count;

    psd_pkg::t_out distance_queue[$];
    int            fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = distance_queue.size();

    // Exact signed product, wide enough for any coordinate difference.
    function automatic logic signed [127:0] wide_mul(longint a, longint b);
        logic signed [127:0] x;
        logic signed [127:0] y;
        x = a;
        y = b;
        return x * y;
    endfunction

    // Component of the edge scaled by the projection fraction, rounded half away from zero.
    function automatic longint scale_component(longint v, logic [127:0] frac);
        logic [127:0] v_mag;
        logic [127:0] p;
        v_mag = (v < 0) ? -v : v;
        p = ((v_mag * frac) + (128'd1 << 31)) >> 32;
        return (v < 0) ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    // Distance from the query to the segment a-b, floored and saturated.
    function automatic logic [63:0] edge_distance(longint ax, longint ay, longint bx,
                                                  longint by, longint qx, longint qy);
        longint              abx, aby, aqx, aqy, ex, ey;
        logic signed [127:0] dot, len;
        logic [127:0]        frac, num, len_u, sum, csq;
        logic [63:0]         root, c;
        abx = bx - ax;
        aby = by - ay;
        aqx = qx - ax;
        aqy = qy - ay;
        dot = wide_mul(aqx, abx) + wide_mul(aqy, aby);
        len = wide_mul(abx, abx) + wide_mul(aby, aby);
        if (len == 0 || dot <= 0) begin
            frac = '0;
        end else if (dot >= len) begin
            frac = 128'd1 << 32;
        end else begin
            num   = dot;
            len_u = len;
            frac  = (num << 32) / len_u;
        end
        ex = aqx - scale_component(abx, frac);
        ey = aqy - scale_component(aby, frac);
        sum = wide_mul(ex, ex) + wide_mul(ey, ey);
        root = '0;
        for (int b = 63; b >= 0; b--) begin
            c   = root | (64'd1 << b);
            csq = {64'd0, c} * {64'd0, c};
            if (csq <= sum) root = c;
        end
        return (root > SAT_MAX) ? SAT_MAX : root;
    endfunction

    // Even-odd test: does the rightward ray from the query cross edge a-b?
    function automatic logic ray_crosses(longint ax, longint ay, longint bx, longint by,
                                         longint qx, longint qy);
        longint              dy;
        logic signed [127:0] lhs, rhs;
        if ((ay > qy) == (by > qy)) return 1'b0;
        dy  = by - ay;
        lhs = wide_mul(qx - ax, dy);
        rhs = wide_mul(bx - ax, qy - ay);
        return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
    endfunction

    function automatic void fold_edge(longint ax, longint ay, longint bx, longint by,
                                      longint qx, longint qy);
        logic [63:0] d;
        d = edge_distance(ax, ay, bx, by, qx, qy);
        if (d < nearest) nearest = d;
        if (ray_crosses(ax, ay, bx, by, qx, qy)) odd_crossings = ~odd_crossings;
    endfunction

    // Fold one vertex into the polygon; queue a result on a last vertex.
    function automatic void fold_vertex(psd_pkg::t_in v);
        longint        qx, qy, vx, vy;
        psd_pkg::t_out r;
        qx = v.query_x;
        qy = v.query_y;
        vx = v.vertex_x;
        vy = v.vertex_y;
        if (v.first_vertex || vertex_count == 0) begin
            nearest       = SAT_MAX;
            odd_crossings = 1'b0;
            first_x       = vx;
            first_y       = vy;
            vertex_count  = 1;
        end else begin
            fold_edge(last_x, last_y, vx, vy, qx, qy);
            if (vertex_count < 3) vertex_count++;
        end
        last_x = vx;
        last_y = vy;
        if (!v.last_vertex) return;
        if (vertex_count >= 3) begin
            fold_edge(vx, vy, first_x, first_y, qx, qy);
            r.signed_distance  = odd_crossings ? -nearest[31:0] : nearest[31:0];
            r.is_inside        = odd_crossings;
            r.too_few_vertices = 1'b0;
        end else begin
            r.signed_distance  = SAT_MAX[31:0];
            r.is_inside        = 1'b0;
            r.too_few_vertices = 1'b1;
        end
        distance_queue = {distance_queue, r};
        nearest       = SAT_MAX;
        odd_crossings = 1'b0;
        vertex_count  = 0;
    endfunction

    initial begin
        fail_count = 0;
    end

    // Watch both channels at each rising edge.
    always @(posedge i_clk) begin
        psd_pkg::t_out want;
        if (!i_rst_n) begin
            first_x       = 0;
            first_y       = 0;
            last_x        = 0;
            last_y        = 0;
            nearest       = SAT_MAX;
            odd_crossings = 1'b0;
            vertex_count  = 0;
        end else begin
            if (i_in_valid && !i_in_stall) fold_vertex(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (distance_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result transaction: %p", i_out_data);
                end else begin
                    want = distance_queue.pop_front();
                    if (want.signed_distance  !== i_out_data.signed_distance ||
                        want.is_inside        !== i_out_data.is_inside ||
                        want.too_few_vertices !== i_out_data.too_few_vertices) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, got %p", want, i_out_data);
                    end
                end
            end
        end
    end

endmodule

// ===== sim/polygon_signed_distance_tb.sv =====
// Testbench top: clock, reset, vertex stimulus and the final verdict.
`timescale 1ns / 100ps

module polygon_signed_distance_tb;

    logic          i_clk;
    logic          i_rst_n;
    logic          in_valid;
    logic          in_stall;
    psd_pkg::t_in  in_data;
    logic          out_valid;
    logic          out_stall;
    psd_pkg::t_out out_data;
    int            fail_count;
    int            pending;

    int    vertices_sent;
    int    burst_left;
    int    long_hold_request;

    polygon_signed_distance u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    polygon_signed_distance_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Run limit, far beyond the slowest legal run.
    initial begin
        #200_000_000;
        $display("polygon_signed_distance_tb: errors");
        $finish;
    end

    // Receiver: stall percentage redrawn whenever the phase counter wraps; long hold-offs on request.
    initial begin
        int hold_cycles;
        int stall_pct;
        int phase;
        hold_cycles = 0;
        stall_pct   = 0;
        phase       = 0;
        out_stall   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (phase == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 20;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            phase = (phase + 1) % 64;
            if (long_hold_request != 0) begin
                hold_cycles       = long_hold_request;
                long_hold_request = 0;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one vertex and hold it until it is accepted.
    task automatic send_vertex(longint qx, longint qy, longint vx, longint vy,
                               bit first, bit last);
        psd_pkg::t_in v;
        v.query_x      = qx[31:0];
        v.query_y      = qy[31:0];
        v.vertex_x     = vx[31:0];
        v.vertex_y     = vy[31:0];
        v.first_vertex = first;
        v.last_vertex  = last;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_data  <= v;
        do @(posedge i_clk); while (in_stall);
        vertices_sent++;
        if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge i_clk);
            end
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic longint pick_coord(int spread);
        case (spread)
            0: return longint'($urandom_range(0, 32768)) - 16384;
            1: return longint'($urandom_range(0, 1 << 24)) - (1 << 23);
            default: return longint'(int'($urandom));
        endcase
    endfunction

    // A random polygon; mostly well formed, sometimes with odd marks or a moving query.
    task automatic send_random_polygon();
        int     n, spread;
        longint qx, qy;
        bit     drop_first, shift_query, early_last;
        n           = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        spread      = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 2);
        qx          = pick_coord(spread);
        qy          = pick_coord(spread);
        drop_first  = ($urandom_range(0, 9) == 0);
        shift_query = ($urandom_range(0, 9) == 0);
        early_last  = ($urandom_range(0, 19) == 0);
        for (int k = 0; k < n; k++) begin
            if (shift_query) begin
                qx = pick_coord(spread);
                qy = pick_coord(spread);
            end
            send_vertex(qx, qy, pick_coord(spread), pick_coord(spread),
                        (k == 0) && !drop_first,
                        (k == n - 1) || (early_last && $urandom_range(0, 3) == 0));
        end
    endtask

    initial begin
        longint lo, hi;
        lo                = -64'sd2147483648;
        hi                = 64'sd2147483647;
        i_rst_n           = 1'b0;
        in_valid          = 1'b0;
        in_data           = '0;
        vertices_sent     = 0;
        burst_left        = 4;
        long_hold_request = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Square around the query: inside, so the distance comes out negative.
        send_vertex(0, 0, -4096, -4096, 1, 0);
        send_vertex(0, 0,  4096, -4096, 0, 0);
        send_vertex(0, 0,  4096,  4096, 0, 0);
        send_vertex(0, 0, -4096,  4096, 0, 1);
        // Triangle away from the query, first mark missing after a result.
        send_vertex(100000, 5, 0, 0, 0, 0);
        send_vertex(100000, 5, 8192, 0, 0, 0);
        send_vertex(100000, 5, 0, 8192, 0, 1);
        // One vertex that is both first and last, then a two-vertex polygon.
        send_vertex(7, 7, 3, 3, 1, 1);
        send_vertex(7, 7, 3, 3, 1, 0);
        send_vertex(7, 7, 9, 1, 0, 1);
        // Repeated vertex giving a zero-length edge, and a query that moves mid-way.
        send_vertex(10, 10, 100, 100, 1, 0);
        send_vertex(10, 10, 100, 100, 0, 0);
        send_vertex(-50, 30, 300, -20, 0, 0);
        send_vertex(60, -90, -200, 40, 0, 1);
        // Extreme coordinates, with a restart of the polygon while one is open.
        send_vertex(lo, hi, lo, lo, 1, 0);
        send_vertex(hi, lo, hi, lo, 1, 0);
        send_vertex(hi, lo, hi, hi, 0, 0);
        send_vertex(lo, lo, lo, hi, 0, 1);
        send_vertex(0, 0, hi, hi, 1, 0);
        send_vertex(0, 0, lo, lo, 0, 0);
        send_vertex(0, 0, hi, lo, 0, 1);
        drain_results();

        // Random polygons, with one long receiver hold-off and one full drain.
        while (vertices_sent < 1770) begin
            if (vertices_sent >= 600 && vertices_sent < 608)
                long_hold_request = 400;
            if (vertices_sent >= 1200 && vertices_sent < 1208) begin
                @(negedge i_clk);
                in_valid <= 1'b0;
                wait (pending == 0);
            end
            send_random_polygon();
        end
        drain_results();

        if (fail_count == 0)
            $display("polygon_signed_distance_tb: clean");
        else
            $display("polygon_signed_distance_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/psd_pkg.sv
rtl/psd_ctrl.sv
rtl/psd_dp.sv
rtl/polygon_signed_distance.sv
rtl/psd_checker.sv
sim/polygon_signed_distance_checker.sv
sim/polygon_signed_distance_tb.sv
